FILE: rtl/core/telemetry_frame_synchronizer_assert.svh
// Assertion helpers shared by the frame synchroniser RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TELEMETRY_FRAME_SYNCHRONIZER_ASSERT_SVH
`define TELEMETRY_FRAME_SYNCHRONIZER_ASSERT_SVH

// Same-cycle implication.
`define TFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/tfs_pkg.sv
`default_nettype none

package tfs_pkg;

	localparam int MAX_FRAME_LEN = 64;
	localparam int IDX_W         = $clog2(MAX_FRAME_LEN);
	localparam int CNT_W         = $clog2(MAX_FRAME_LEN + 1);
	localparam int CHUNK         = 8;
	localparam int CHUNK_SEL_W   = $clog2(CHUNK);
	localparam int NCHUNK        = MAX_FRAME_LEN / CHUNK;
	localparam int CHUNK_W       = $clog2(NCHUNK);
	localparam int MIN_FRAME_LEN = 4;

	localparam int SYNC_W        = 16;
	localparam int FLEN_W        = 7;
	localparam int OUT_IDX_W     = 6;

	localparam logic REG_SYNC_WORD = 1'b0;
	localparam logic REG_FRAME_LEN = 1'b1;

	localparam logic KIND_TELEMETRY = 1'b0;
	localparam logic KIND_SCAN      = 1'b1;

	typedef struct packed {
		logic tel;
		logic scn;
	} tfs_match_t;

	typedef struct packed {
		logic shift;
		logic load;
	} tfs_cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRESHIFT,
		ST_INSERT,
		ST_CHECK,
		ST_EMIT,
		ST_DROP,
		ST_SCAN
	} tfs_state_t;

	// Sync pair test: a is the earlier byte on the wire, b the later one.
	function automatic tfs_match_t tfs_pair(input logic [7:0] a, input logic [7:0] b,
			input logic [SYNC_W-1:0] sw);
		tfs_match_t m;
		m.tel = (a == sw[7:0]) && (b == sw[15:8]);
		m.scn = (a == ~sw[7:0]) && (b == ~sw[15:8]);
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tfs_cell.sv
`default_nettype none

// One held byte. Shifting moves every byte one place towards the oldest end.
module tfs_cell
	import tfs_pkg::*;
(
	input  wire logic                clk,
	input  wire tfs_cell_ctrl_t      ctrl,
	input  wire logic [7:0]          din,
	input  wire logic [7:0]          up,
	input  wire logic [SYNC_W-1:0]   sync_word,
	output logic [7:0]               q,
	output tfs_match_t               match
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= din;
		end else if (ctrl.shift) begin
			byte_q <= up;
		end
	end

	assign q     = byte_q;
	// This byte with the next newer one as a candidate sync pair.
	assign match = tfs_pair(byte_q, up, sync_word);

endmodule

`default_nettype wire

FILE: rtl/core/telemetry_frame_synchronizer.sv
// Channel  | Valid     | Stall     | Payload
// ---------+-----------+-----------+----------------------------------------------
// input    | in_valid  | in_stall  | rx_byte
// output   | out_valid | out_stall | frame_byte, byte_index, frame_kind, last_in_frame
// config   | cfg_we    | (none)    | cfg_index, cfg_data
//
// A byte that completes no frame passes through accept, insert and frame check.
// An emitted frame adds a shift per byte taken, then a hunt scan over the pair flags
// (eight cells at a time) and another frame check; a drop adds one shift per byte,
// a closing step, the scan and the check. A full row costs one extra shift
// and a scan first. Reset clears control state only; the byte cells are never cleared.
// Output stalls hold the row in place; in_stall is high whenever the block is busy.
`default_nettype none

`include "telemetry_frame_synchronizer_assert.svh"

module telemetry_frame_synchronizer
	import tfs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [SYNC_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                frame_byte,
	output logic [OUT_IDX_W-1:0]      byte_index,
	output logic                      frame_kind,
	output logic                      last_in_frame
);

	tfs_state_t state_q, state_d;

	logic [SYNC_W-1:0]  sync_word_q;
	logic [FLEN_W-1:0]  frame_len_q;
	logic [CNT_W-1:0]   held_q, held_d;
	logic               locked_q, locked_d;
	logic [7:0]         prev_q, prev_d;
	logic               seen_q, seen_d;
	logic [IDX_W-1:0]   pos_q, pos_d;
	logic [CNT_W-1:0]   drop_q, drop_d;
	logic [IDX_W-1:0]   emit_idx_q, emit_idx_d;
	logic               kind_q, kind_d;
	logic [CHUNK_W-1:0] chunk_q, chunk_d;
	logic               ret_ins_q, ret_ins_d;
	logic [7:0]         in_byte_q;

	logic [CNT_W-1:0]   len_eff;
	logic [CNT_W-1:0]   after;
	logic               do_shift, do_load, take_in, out_take, emit_last;
	tfs_match_t         in_match, tail_match;
	logic [CHUNK-1:0]   chunk_flags;
	logic               chunk_hit;
	logic [CHUNK_SEL_W-1:0] chunk_enc;

	logic [7:0]         cell_q  [MAX_FRAME_LEN];
	logic [7:0]         cell_up [MAX_FRAME_LEN];
	tfs_match_t         match   [MAX_FRAME_LEN];
	tfs_cell_ctrl_t     cell_ctrl [MAX_FRAME_LEN];
	logic [MAX_FRAME_LEN-1:0] flag;

	// Row of cells, oldest held byte in cell 0.
	for (genvar g = 0; g < MAX_FRAME_LEN; g++) begin : g_cell
		if (g == MAX_FRAME_LEN - 1) begin : g_top
			assign cell_up[g] = '0;
		end else begin : g_mid
			assign cell_up[g] = cell_q[g+1];
		end
		assign cell_ctrl[g].shift = do_shift;
		assign cell_ctrl[g].load  = do_load && (held_q == CNT_W'(g));
		tfs_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[g]),
			.din       (in_byte_q),
			.up        (cell_up[g]),
			.sync_word (sync_word_q),
			.q         (cell_q[g]),
			.match     (match[g])
		);
	end

	// A pair flag counts only where both of its bytes are held.
	always_comb begin
		for (int i = 0; i < MAX_FRAME_LEN; i++) begin
			flag[i] = (match[i].tel || match[i].scn) && (CNT_W'(i + 1) < held_q);
		end
	end

	always_comb begin
		if (CNT_W'(frame_len_q) < CNT_W'(MIN_FRAME_LEN)) begin
			len_eff = CNT_W'(MIN_FRAME_LEN);
		end else if (CNT_W'(frame_len_q) > CNT_W'(MAX_FRAME_LEN)) begin
			len_eff = CNT_W'(MAX_FRAME_LEN);
		end else begin
			len_eff = CNT_W'(frame_len_q);
		end
	end

	assign in_match   = tfs_pair(prev_q, in_byte_q, sync_word_q);
	assign tail_match = match[IDX_W'(len_eff - CNT_W'(2))];
	assign after      = CNT_W'(pos_q) + CNT_W'(2);

	assign chunk_flags = flag[chunk_q * CHUNK +: CHUNK];
	always_comb begin
		chunk_hit = 1'b0;
		chunk_enc = '0;
		for (int k = CHUNK - 1; k >= 0; k--) begin
			if (chunk_flags[k]) begin
				chunk_hit = 1'b1;
				chunk_enc = CHUNK_SEL_W'(k);
			end
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign take_in       = in_valid && (state_q == ST_IDLE);
	assign out_valid     = (state_q == ST_EMIT);
	assign out_take      = out_valid && !out_stall;
	assign emit_last     = (CNT_W'(emit_idx_q) == len_eff - CNT_W'(1));
	assign frame_byte    = cell_q[0];
	assign byte_index    = OUT_IDX_W'(emit_idx_q);
	assign frame_kind    = kind_q;
	assign last_in_frame = emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		held_d     = held_q;
		locked_d   = locked_q;
		prev_d     = prev_q;
		seen_d     = seen_q;
		pos_d      = pos_q;
		drop_d     = drop_q;
		emit_idx_d = emit_idx_q;
		kind_d     = kind_q;
		chunk_d    = chunk_q;
		ret_ins_d  = ret_ins_q;
		do_shift   = 1'b0;
		do_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take_in) begin
					state_d = (held_q == CNT_W'(MAX_FRAME_LEN)) ? ST_PRESHIFT : ST_INSERT;
				end
			end
			ST_PRESHIFT: begin
				do_shift  = 1'b1;
				held_d    = held_q - CNT_W'(1);
				chunk_d   = '0;
				ret_ins_d = 1'b1;
				state_d   = ST_SCAN;
			end
			ST_INSERT: begin
				if ((held_q != '0) && !seen_q && (in_match.tel || in_match.scn)) begin
					seen_d = 1'b1;
					pos_d  = IDX_W'(held_q - CNT_W'(1));
				end
				do_load = 1'b1;
				held_d  = held_q + CNT_W'(1);
				prev_d  = in_byte_q;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (held_q < len_eff) begin
					state_d = ST_IDLE;
				end else if (locked_q && (tail_match.tel || tail_match.scn)) begin
					kind_d     = tail_match.tel ? KIND_TELEMETRY : KIND_SCAN;
					emit_idx_d = '0;
					state_d    = ST_EMIT;
				end else if (seen_q) begin
					// Realign on the earliest pair; keep a whole frame ending in it, else drop through the pair.
					locked_d = 1'b1;
					drop_d   = (after >= len_eff) ? (after - len_eff) : after;
					state_d  = ST_DROP;
				end else begin
					locked_d = 1'b0;
					drop_d   = CNT_W'(1);
					state_d  = ST_DROP;
				end
			end
			ST_EMIT: begin
				if (out_take) begin
					do_shift   = 1'b1;
					held_d     = held_q - CNT_W'(1);
					emit_idx_d = emit_idx_q + IDX_W'(1);
					if (emit_last) begin
						chunk_d   = '0;
						ret_ins_d = 1'b0;
						state_d   = ST_SCAN;
					end
				end
			end
			ST_DROP: begin
				if ((drop_q == '0) || (held_q == '0)) begin
					chunk_d   = '0;
					ret_ins_d = 1'b0;
					state_d   = ST_SCAN;
				end else begin
					do_shift = 1'b1;
					held_d   = held_q - CNT_W'(1);
					drop_d   = drop_q - CNT_W'(1);
				end
			end
			ST_SCAN: begin
				if (chunk_hit) begin
					seen_d  = 1'b1;
					pos_d   = {chunk_q, chunk_enc};
					state_d = ret_ins_q ? ST_INSERT : ST_CHECK;
				end else if (chunk_q == CHUNK_W'(NCHUNK - 1)) begin
					seen_d  = 1'b0;
					pos_d   = '0;
					state_d = ret_ins_q ? ST_INSERT : ST_CHECK;
				end else begin
					chunk_d = chunk_q + CHUNK_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= '0;
			frame_len_q <= FLEN_W'(MAX_FRAME_LEN);
			held_q      <= '0;
			locked_q    <= 1'b0;
			prev_q      <= '0;
			seen_q      <= 1'b0;
			pos_q       <= '0;
			drop_q      <= '0;
			emit_idx_q  <= '0;
			kind_q      <= 1'b0;
			chunk_q     <= '0;
			ret_ins_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SYNC_WORD: sync_word_q <= cfg_data;
					REG_FRAME_LEN: frame_len_q <= cfg_data[FLEN_W-1:0];
					default: ;
				endcase
			end
			held_q     <= held_d;
			locked_q   <= locked_d;
			prev_q     <= prev_d;
			seen_q     <= seen_d;
			pos_q      <= pos_d;
			drop_q     <= drop_d;
			emit_idx_q <= emit_idx_d;
			kind_q     <= kind_d;
			chunk_q    <= chunk_d;
			ret_ins_q  <= ret_ins_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			in_byte_q <= rx_byte;
		end
	end

	`TFS_ASSERT_NOW(a_held_bound, 1'b1, held_q <= CNT_W'(MAX_FRAME_LEN),
		"held byte count exceeds the row length")
	`TFS_ASSERT_NOW(a_emit_nonempty, out_valid, held_q != '0,
		"request offered from an empty row")
	`TFS_ASSERT_NEXT(a_last_then_scan, out_take && last_in_frame, state_q == ST_SCAN,
		"final byte of a frame not followed by a hunt scan")
	`TFS_ASSERT_NOW(a_idle_below_frame,
		(state_q == ST_IDLE) && ($past(state_q) == ST_CHECK), held_q < len_eff,
		"returned to idle with a whole frame still held")
	`TFS_ASSERT_NOW(a_pair_inside, (state_q == ST_IDLE) && seen_q,
		CNT_W'(pos_q) + CNT_W'(2) <= held_q,
		"recorded sync pair lies beyond the held bytes")

endmodule

`default_nettype wire
